// File: rtl/rmfh_pkg.sv
// Shared types, operation codes and helper functions of the ray/mesh first-hit block.
// Used by rmfh_ctrl, rmfh_dp and ray_mesh_first_hit; depends on nothing else.
`default_nettype none

package rmfh_pkg;

  localparam logic [15:0] COUNT_CAP = 16'hFFFF;

  localparam logic [2:0] K_CULL = 3'd0;
  localparam logic [2:0] K_CRSP = 3'd1;
  localparam logic [2:0] K_CRSQ = 3'd2;
  localparam logic [2:0] K_DET  = 3'd3;
  localparam logic [2:0] K_UN   = 3'd4;
  localparam logic [2:0] K_VN   = 3'd5;
  localparam logic [2:0] K_TN   = 3'd6;
  localparam logic [2:0] K_HIT  = 3'd7;

  localparam logic [2:0] SUB_LIM = 3'd3;

  typedef struct packed {
    logic [2:0] kind;
    logic [2:0] sub;
  } op_t;

  typedef struct packed {
    logic load;
    logic op_vld;
    op_t  op;
    logic norm;
    logic div_init;
    logic div_step;
    logic take;
    logic count;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic found;
    logic last;
    logic reject;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic [30:0]        max_distance;
  } cfg_t;

  function automatic logic signed [31:0] sat32(input logic signed [51:0] v);
    if (v > 52'sh0_0000_7FFF_FFFF) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -52'sh0_0000_8000_0000) begin
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [1:0] nxt3(input logic [1:0] c);
    return (c == 2'd2) ? 2'd0 : c + 2'd1;
  endfunction

  function automatic logic [2:0] last_sub(input logic [2:0] kind);
    case (kind)
      K_CULL:         return SUB_LIM;
      K_CRSP, K_CRSQ: return 3'd5;
      default:        return 3'd2;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/ray_mesh_first_hit.sv
// Ray/mesh first-hit: one configured ray tested against a stream of triangles, one at a time.
// A triangle is skipped once a hit is kept, runs the dot products on the shared multiplier when
// culled or missed, and also runs the 31-step divider for the first hit; a last triangle adds the
// hit-point products and waits out any output stall. Results come with out_valid; one transaction
// per mesh. Reset is synchronous, active low, clears the kept hit, the triangle count and the
// output valid flag, and returns the ray registers to their defaults.
`default_nettype none

module ray_mesh_first_hit import rmfh_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [4:0]          paddr,
  input  wire [31:0]         pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  wire                in_valid,
  output logic               in_stall,
  input  wire signed [31:0]  in_a_x,
  input  wire signed [31:0]  in_a_y,
  input  wire signed [31:0]  in_a_z,
  input  wire signed [31:0]  in_b_x,
  input  wire signed [31:0]  in_b_y,
  input  wire signed [31:0]  in_b_z,
  input  wire signed [31:0]  in_c_x,
  input  wire signed [31:0]  in_c_y,
  input  wire signed [31:0]  in_c_z,
  input  wire                in_last_triangle,
  output logic               out_valid,
  input  wire                out_stall,
  output logic               out_hit,
  output logic signed [31:0] out_hit_t,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z,
  output logic [15:0]        out_hit_index
);

  localparam logic [2:0] REG_ORIGIN_X = 3'd0;
  localparam logic [2:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [2:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [2:0] REG_DIR_X    = 3'd3;
  localparam logic [2:0] REG_DIR_Y    = 3'd4;
  localparam logic [2:0] REG_DIR_Z    = 3'd5;
  localparam logic [2:0] REG_MAX_DIST = 3'd6;

  cfg_t cfg_r;
  cmd_t cmd;
  sts_t sts;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
      cfg_r.origin_z     <= '0;
      cfg_r.dir_x        <= '0;
      cfg_r.dir_y        <= '0;
      cfg_r.dir_z        <= 32'sh0001_0000;
      cfg_r.max_distance <= 31'h0001_0000;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_ORIGIN_X: cfg_r.origin_x     <= pwdata;
        REG_ORIGIN_Y: cfg_r.origin_y     <= pwdata;
        REG_ORIGIN_Z: cfg_r.origin_z     <= pwdata;
        REG_DIR_X:    cfg_r.dir_x        <= pwdata;
        REG_DIR_Y:    cfg_r.dir_y        <= pwdata;
        REG_DIR_Z:    cfg_r.dir_z        <= pwdata;
        REG_MAX_DIST: cfg_r.max_distance <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_ORIGIN_X: prdata = cfg_r.origin_x;
      REG_ORIGIN_Y: prdata = cfg_r.origin_y;
      REG_ORIGIN_Z: prdata = cfg_r.origin_z;
      REG_DIR_X:    prdata = cfg_r.dir_x;
      REG_DIR_Y:    prdata = cfg_r.dir_y;
      REG_DIR_Z:    prdata = cfg_r.dir_z;
      REG_MAX_DIST: prdata = {1'b0, cfg_r.max_distance};
      default:      prdata = '0;
    endcase
  end

  rmfh_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  rmfh_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg              (cfg_r),
    .cmd              (cmd),
    .sts              (sts),
    .in_a_x           (in_a_x),
    .in_a_y           (in_a_y),
    .in_a_z           (in_a_z),
    .in_b_x           (in_b_x),
    .in_b_y           (in_b_y),
    .in_b_z           (in_b_z),
    .in_c_x           (in_c_x),
    .in_c_y           (in_c_y),
    .in_c_z           (in_c_z),
    .in_last_triangle (in_last_triangle),
    .out_stall        (out_stall),
    .out_valid        (out_valid),
    .out_hit          (out_hit),
    .out_hit_t        (out_hit_t),
    .out_hit_x        (out_hit_x),
    .out_hit_y        (out_hit_y),
    .out_hit_z        (out_hit_z),
    .out_hit_index    (out_hit_index)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted on consecutive cycles");

  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_hit) |-> (out_hit_t == 32'sd0 && out_hit_index == 16'd0))
    else $error("miss transaction carries nonzero t or index");

  a_hit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_hit) |-> (out_hit_t <= $signed({1'b0, cfg_r.max_distance})))
    else $error("hit transaction beyond max distance");

endmodule

`default_nettype wire

// File: rtl/rmfh_ctrl.sv
// Sequencer of the ray/mesh first-hit block: steps the shared multiplier, divider and result.
// Depends on rmfh_pkg.
`default_nettype none

module rmfh_ctrl import rmfh_pkg::*; (
  input  wire  clk,
  input  wire  rst_n,
  input  wire  in_valid,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MUL    = 4'd1;
  localparam logic [3:0] S_DRAIN  = 4'd2;
  localparam logic [3:0] S_EVAL1  = 4'd3;
  localparam logic [3:0] S_EVAL2  = 4'd4;
  localparam logic [3:0] S_DIV    = 4'd5;
  localparam logic [3:0] S_TAKE   = 4'd6;
  localparam logic [3:0] S_COUNT  = 4'd7;
  localparam logic [3:0] S_HIT    = 4'd8;
  localparam logic [3:0] S_HDRAIN = 4'd9;
  localparam logic [3:0] S_OUT    = 4'd10;

  localparam logic [4:0] DIV_LAST = 5'd30;

  logic [3:0] state_r, state_nxt;
  logic [2:0] kind_r, kind_nxt;
  logic [2:0] sub_r, sub_nxt;
  logic [4:0] cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_CULL;
      sub_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      sub_r   <= sub_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    sub_nxt     = sub_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.op.kind = kind_r;
    cmd.op.sub  = sub_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          kind_nxt = K_CULL;
          sub_nxt  = '0;
          state_nxt = sts.found ? S_COUNT : S_MUL;
        end
      end
      S_MUL: begin
        cmd.op_vld = 1'b1;
        if (sub_r == last_sub(kind_r)) begin
          sub_nxt = '0;
          if (kind_r == K_TN) begin
            state_nxt = S_DRAIN;
          end else begin
            kind_nxt = kind_r + 3'd1;
          end
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      S_DRAIN: state_nxt = S_EVAL1;
      S_EVAL1: begin
        cmd.norm  = 1'b1;
        state_nxt = S_EVAL2;
      end
      S_EVAL2: begin
        if (sts.reject) begin
          state_nxt = S_COUNT;
        end else begin
          cmd.div_init = 1'b1;
          cnt_nxt      = '0;
          state_nxt    = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt_r == DIV_LAST) begin
          state_nxt = S_TAKE;
        end else begin
          cnt_nxt = cnt_r + 5'd1;
        end
      end
      S_TAKE: begin
        cmd.take  = 1'b1;
        state_nxt = S_COUNT;
      end
      S_COUNT: begin
        cmd.count = 1'b1;
        if (sts.last) begin
          kind_nxt  = K_HIT;
          sub_nxt   = '0;
          state_nxt = S_HIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_HIT: begin
        cmd.op_vld = 1'b1;
        if (sub_r == last_sub(kind_r)) begin
          state_nxt = S_HDRAIN;
        end else begin
          sub_nxt = sub_r + 3'd1;
        end
      end
      S_HDRAIN: state_nxt = S_OUT;
      S_OUT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/rmfh_dp.sv
// Datapath of the ray/mesh first-hit block: vertex capture, shared 33x33 multiplier,
// accumulators, bit-serial divider, kept hit and output register. Depends on rmfh_pkg.
`default_nettype none

module rmfh_dp import rmfh_pkg::*; (
  input  wire                clk,
  input  wire                rst_n,
  input  cfg_t               cfg,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  wire signed [31:0]  in_a_x,
  input  wire signed [31:0]  in_a_y,
  input  wire signed [31:0]  in_a_z,
  input  wire signed [31:0]  in_b_x,
  input  wire signed [31:0]  in_b_y,
  input  wire signed [31:0]  in_b_z,
  input  wire signed [31:0]  in_c_x,
  input  wire signed [31:0]  in_c_y,
  input  wire signed [31:0]  in_c_z,
  input  wire                in_last_triangle,
  input  wire                out_stall,
  output logic               out_valid,
  output logic               out_hit,
  output logic signed [31:0] out_hit_t,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z,
  output logic [15:0]        out_hit_index
);

  logic signed [31:0] a_v [3];
  logic signed [31:0] b_v [3];
  logic signed [31:0] c_v [3];
  logic signed [31:0] org_v [3];
  logic signed [31:0] dir_v [3];
  logic signed [32:0] dif_v [3];
  logic [32:0]        dabs_v [3];
  logic [31:0]        lim;
  logic               far_v;

  logic signed [31:0] e1_r [3];
  logic signed [31:0] e2_r [3];
  logic signed [31:0] s_r [3];
  logic signed [31:0] p_r [3];
  logic signed [31:0] q_r [3];
  logic signed [31:0] hp_r [3];
  logic [32:0]        d_r [3];
  logic               far_r;
  logic               last_r;

  logic signed [32:0] ma, mb;
  logic [1:0]         cmp, c1, c2, ix, ix1, cmp1;
  logic signed [65:0] prod_r;
  op_t                op1_r;
  logic               vld1_r;
  logic signed [47:0] mulq;
  logic signed [49:0] dot_sum;

  logic [65:0]        sum_r, limsq_r;
  logic signed [47:0] tmp_r;
  logic signed [49:0] acc_r, det_r, un_r, vn_r, tn_r;
  logic               cull_r;
  logic signed [50:0] ndet_r, nun_r, nvn_r, ntn_r;
  logic               neg;
  logic [50:0]        nmag;
  logic [50:0]        dv_r, rem_r;
  logic [30:0]        nlo_r, qt_r, tmag;
  logic               sat_r, tneg_r;
  logic [51:0]        r2;
  logic               ge;

  logic               found_r;
  logic signed [31:0] found_t_r;
  logic [15:0]        found_index_r, tri_count_r;
  logic               hitf_r;
  logic signed [31:0] ht_r;
  logic               out_valid_r;

  always_comb begin
    a_v[0] = in_a_x; a_v[1] = in_a_y; a_v[2] = in_a_z;
    b_v[0] = in_b_x; b_v[1] = in_b_y; b_v[2] = in_b_z;
    c_v[0] = in_c_x; c_v[1] = in_c_y; c_v[2] = in_c_z;
    org_v[0] = cfg.origin_x; org_v[1] = cfg.origin_y; org_v[2] = cfg.origin_z;
    dir_v[0] = cfg.dir_x; dir_v[1] = cfg.dir_y; dir_v[2] = cfg.dir_z;
    lim   = 32'({1'b0, cfg.max_distance}) + 32'h0001_0000;
    far_v = 1'b0;
    for (int i = 0; i < 3; i++) begin
      dif_v[i]  = 33'(a_v[i]) - 33'(org_v[i]);
      dabs_v[i] = dif_v[i][32] ? 33'(-dif_v[i]) : 33'(dif_v[i]);
      far_v     = far_v | (dabs_v[i] > {1'b0, lim});
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int i = 0; i < 3; i++) begin
        e1_r[i] <= sat32(52'(b_v[i]) - 52'(a_v[i]));
        e2_r[i] <= sat32(52'(c_v[i]) - 52'(a_v[i]));
        s_r[i]  <= sat32(52'(org_v[i]) - 52'(a_v[i]));
        d_r[i]  <= dabs_v[i];
      end
      far_r  <= far_v;
      last_r <= in_last_triangle;
    end
  end

  always_comb begin
    cmp = cmd.op.sub[2:1];
    c1  = nxt3(cmp);
    c2  = nxt3(c1);
    ix  = cmd.op.sub[1:0];
    ma  = '0;
    mb  = '0;
    case (cmd.op.kind)
      K_CULL: begin
        if (cmd.op.sub == SUB_LIM) begin
          ma = 33'({1'b0, lim});
          mb = 33'({1'b0, lim});
        end else begin
          ma = d_r[ix];
          mb = d_r[ix];
        end
      end
      K_CRSP: begin
        ma = 33'(cmd.op.sub[0] ? dir_v[c2] : dir_v[c1]);
        mb = 33'(cmd.op.sub[0] ? e2_r[c1] : e2_r[c2]);
      end
      K_CRSQ: begin
        ma = 33'(cmd.op.sub[0] ? s_r[c2] : s_r[c1]);
        mb = 33'(cmd.op.sub[0] ? e1_r[c1] : e1_r[c2]);
      end
      K_DET: begin
        ma = 33'(e1_r[ix]);
        mb = 33'(p_r[ix]);
      end
      K_UN: begin
        ma = 33'(s_r[ix]);
        mb = 33'(p_r[ix]);
      end
      K_VN: begin
        ma = 33'(dir_v[ix]);
        mb = 33'(q_r[ix]);
      end
      K_TN: begin
        ma = 33'(e2_r[ix]);
        mb = 33'(q_r[ix]);
      end
      default: begin
        ma = 33'(dir_v[ix]);
        mb = 33'(ht_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= cmd.op_vld;
    end
    prod_r <= ma * mb;
    op1_r  <= cmd.op;
  end

  assign mulq    = prod_r[63:16];
  assign dot_sum = acc_r + 50'(mulq);
  assign ix1     = op1_r.sub[1:0];
  assign cmp1    = op1_r.sub[2:1];

  always_ff @(posedge clk) begin
    if (vld1_r) begin
      case (op1_r.kind)
        K_CULL: begin
          if (op1_r.sub == SUB_LIM) begin
            limsq_r <= $unsigned(prod_r);
          end else if (op1_r.sub == 3'd0) begin
            sum_r <= $unsigned(prod_r);
          end else begin
            sum_r <= sum_r + $unsigned(prod_r);
          end
        end
        K_CRSP, K_CRSQ: begin
          if (!op1_r.sub[0]) begin
            tmp_r <= mulq;
          end else if (op1_r.kind == K_CRSP) begin
            p_r[cmp1] <= sat32(52'(tmp_r) - 52'(mulq));
          end else begin
            q_r[cmp1] <= sat32(52'(tmp_r) - 52'(mulq));
          end
        end
        K_DET, K_UN, K_VN, K_TN: begin
          if (op1_r.sub == 3'd0) begin
            acc_r <= 50'(mulq);
          end else if (op1_r.sub == 3'd1) begin
            acc_r <= dot_sum;
          end else begin
            case (op1_r.kind)
              K_DET:   det_r <= dot_sum;
              K_UN:    un_r  <= dot_sum;
              K_VN:    vn_r  <= dot_sum;
              default: tn_r  <= dot_sum;
            endcase
          end
        end
        default: hp_r[ix1] <= sat32(52'(org_v[ix1]) + 52'(mulq));
      endcase
    end
  end

  assign neg  = det_r[49];
  assign nmag = ntn_r[50] ? 51'(-ntn_r) : 51'(ntn_r);
  assign r2   = {rem_r, nlo_r[30]};
  assign ge   = (r2 >= {1'b0, dv_r});
  assign tmag = sat_r ? 31'h7FFF_FFFF : qt_r;

  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      cull_r <= far_r || (sum_r > limsq_r);
      ndet_r <= neg ? -51'(det_r) : 51'(det_r);
      nun_r  <= neg ? -51'(un_r) : 51'(un_r);
      nvn_r  <= neg ? -51'(vn_r) : 51'(vn_r);
      ntn_r  <= neg ? -51'(tn_r) : 51'(tn_r);
    end
    if (cmd.div_init) begin
      dv_r   <= ndet_r[50:0];
      sat_r  <= ({15'b0, nmag} >= {ndet_r[50:0], 15'b0});
      rem_r  <= 51'(nmag >> 15);
      nlo_r  <= {nmag[14:0], 16'b0};
      qt_r   <= '0;
      tneg_r <= ntn_r[50];
    end else if (cmd.div_step) begin
      rem_r <= ge ? 51'(r2 - {1'b0, dv_r}) : r2[50:0];
      qt_r  <= {qt_r[29:0], ge};
      nlo_r <= {nlo_r[29:0], 1'b0};
    end
  end

  assign sts.reject = cull_r || (ndet_r == '0) || nun_r[50] || (nun_r > ndet_r) || nvn_r[50] ||
                      ((52'(nun_r) + 52'(nvn_r)) > 52'(ndet_r));
  assign sts.found    = found_r;
  assign sts.last     = last_r;
  assign sts.out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r       <= 1'b0;
      found_t_r     <= '0;
      found_index_r <= '0;
      tri_count_r   <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cmd.take) begin
        found_r       <= 1'b1;
        found_t_r     <= tneg_r ? -32'({1'b0, tmag}) : 32'({1'b0, tmag});
        found_index_r <= tri_count_r;
      end
      if (cmd.count && (tri_count_r != COUNT_CAP)) begin
        tri_count_r <= tri_count_r + 16'd1;
      end
      if (cmd.emit) begin
        found_r       <= 1'b0;
        found_t_r     <= '0;
        found_index_r <= '0;
        tri_count_r   <= '0;
        out_valid_r   <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.count) begin
      hitf_r <= found_r && (found_t_r <= $signed({1'b0, cfg.max_distance}));
      ht_r   <= (found_r && (found_t_r <= $signed({1'b0, cfg.max_distance}))) ? found_t_r : '0;
    end
    if (cmd.emit) begin
      out_hit       <= hitf_r;
      out_hit_t     <= ht_r;
      out_hit_x     <= hp_r[0];
      out_hit_y     <= hp_r[1];
      out_hit_z     <= hp_r[2];
      out_hit_index <= hitf_r ? found_index_r : '0;
    end
  end

  assign out_valid = out_valid_r;

endmodule

`default_nettype wire
